>>> hw/rtl/yrgb_pkg.sv
// Package for the YUYV to scaled RGB converter.
// Holds fixed-point constants, field widths and pipeline stage types.
// No dependencies.
`timescale 1ns / 1ps

package yrgb_pkg;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int COEF_W = 19;               // Q16 coefficients, signed
  localparam int DIFF_W = PIX_W + 1;        // chroma minus offset, signed
  localparam int PROD_W = COEF_W + DIFF_W;  // full product width
  localparam int TERM_W = 25;               // holds any chroma term in Q16
  localparam int FRAC_W = 16;

  // Q16 chroma coefficients, rounded to nearest
  localparam logic signed [COEF_W-1:0] COEF_RV = 19'sd89831;
  localparam logic signed [COEF_W-1:0] COEF_GV = 19'sd45744;
  localparam logic signed [COEF_W-1:0] COEF_GU = 19'sd22127;
  localparam logic signed [COEF_W-1:0] COEF_BU = 19'sd113538;

  // Output scale 220/256
  localparam logic [PIX_W-1:0] SCALE_NUM = 8'd220;
  localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;
  localparam logic [PIX_W-1:0] OUT_MAX   = 8'd219;

  // Input register stage
  typedef struct packed {
    logic [PIX_W-1:0] y0;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] y1;
    logic [PIX_W-1:0] v;
    logic             fe;
  } in_stage_t;

  // Chroma product stage: terms shared by both pixels
  typedef struct packed {
    logic [PIX_W-1:0]         y0;
    logic [PIX_W-1:0]         y1;
    logic signed [TERM_W-1:0] r_term;
    logic signed [TERM_W-1:0] g_term;
    logic signed [TERM_W-1:0] b_term;
    logic                     fe;
  } term_stage_t;

  // One RGB pixel
  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  // Result register stage
  typedef struct packed {
    rgb_t pix0;
    rgb_t pix1;
    logic fe;
  } out_stage_t;

endpackage

>>> hw/rtl/yrgb_in_if.sv
// Input channel interface: one YUYV macropixel per item.
// Depends on yrgb_pkg for widths.
`timescale 1ns / 1ps

interface yrgb_in_if;
  logic                         valid;
  logic                         ready;
  logic [yrgb_pkg::PIX_W-1:0]   luma_first;
  logic [yrgb_pkg::PIX_W-1:0]   chroma_blue;
  logic [yrgb_pkg::PIX_W-1:0]   luma_second;
  logic [yrgb_pkg::PIX_W-1:0]   chroma_red;
  logic                         frame_end_in;

  modport source (
    output valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
    input  ready
  );
  modport sink (
    input  valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
    output ready
  );
endinterface

>>> hw/rtl/yrgb_out_if.sv
// Result channel interface: two scaled RGB pixels per item.
// Depends on yrgb_pkg for widths.
`timescale 1ns / 1ps

interface yrgb_out_if;
  logic                       valid;
  logic                       ready;
  logic [yrgb_pkg::PIX_W-1:0] red_first;
  logic [yrgb_pkg::PIX_W-1:0] green_first;
  logic [yrgb_pkg::PIX_W-1:0] blue_first;
  logic [yrgb_pkg::PIX_W-1:0] red_second;
  logic [yrgb_pkg::PIX_W-1:0] green_second;
  logic [yrgb_pkg::PIX_W-1:0] blue_second;
  logic                       frame_end_out;

  modport source (
    output valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, frame_end_out,
    input  ready
  );
  modport sink (
    input  valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, frame_end_out,
    output ready
  );
endinterface

>>> hw/rtl/yrgb_pixel.sv
// Per-pixel color finish: add luma to the Q16 chroma terms, floor,
// clamp to 0..255 and scale by 220/256. Depends on yrgb_pkg.
`timescale 1ns / 1ps

module yrgb_pixel (
  input  logic [yrgb_pkg::PIX_W-1:0]         y,
  input  logic signed [yrgb_pkg::TERM_W-1:0] r_term,
  input  logic signed [yrgb_pkg::TERM_W-1:0] g_term,
  input  logic signed [yrgb_pkg::TERM_W-1:0] b_term,
  output yrgb_pkg::rgb_t                     rgb
);

  localparam int SUM_W = yrgb_pkg::TERM_W + 2;
  localparam int FLR_W = SUM_W - yrgb_pkg::FRAC_W;
  localparam int PIX_W = yrgb_pkg::PIX_W;

  // Floor the Q16 sum, clamp and scale one channel
  function automatic logic [PIX_W-1:0] finish(input logic [PIX_W-1:0] yv,
                                              input logic signed [yrgb_pkg::TERM_W-1:0] t);
    logic signed [SUM_W-1:0] sum;
    logic signed [FLR_W-1:0] flr;
    logic [PIX_W-1:0]        clip;
    logic [2*PIX_W-1:0]      prod;
    sum  = $signed({{(SUM_W-PIX_W-yrgb_pkg::FRAC_W){1'b0}}, yv, {yrgb_pkg::FRAC_W{1'b0}}})
         + $signed({{(SUM_W-yrgb_pkg::TERM_W){t[yrgb_pkg::TERM_W-1]}}, t});
    // arithmetic shift by 16 floors toward minus infinity
    flr  = sum[SUM_W-1:yrgb_pkg::FRAC_W];
    if (flr[FLR_W-1]) begin
      clip = '0;
    end else if (|flr[FLR_W-2:PIX_W]) begin
      clip = yrgb_pkg::PIX_MAX;
    end else begin
      clip = flr[PIX_W-1:0];
    end
    prod = {{PIX_W{1'b0}}, clip} * {{PIX_W{1'b0}}, yrgb_pkg::SCALE_NUM};
    return prod[2*PIX_W-1:PIX_W];
  endfunction

  assign rgb.r = finish(y, r_term);
  assign rgb.g = finish(y, g_term);
  assign rgb.b = finish(y, b_term);

endmodule

>>> hw/rtl/yuyv_to_rgb_scaled_top.sv
// Top level of the YUYV 4:2:2 to scaled RGB888 converter.
// Depends on yrgb_pkg, yrgb_in_if, yrgb_out_if and yrgb_pixel.
`timescale 1ns / 1ps

// Usage
//   in_if  (sink): one YUYV macropixel per item: luma_first, chroma_blue,
//                  luma_second, chroma_red and the frame_end_in flag.
//   out_if (source): two RGB pixels per item, each channel in 0..219,
//                  plus frame_end_out, a copy of the input flag.
//   Each input item gives exactly one result item, in order.
// Timing
//   Three register stages: input register, chroma product register
//   (the constant multiplies, shared by both pixels) and result register.
//   An accepted item passes the input, product and result registers in turn.
//   One item per cycle while out_if.ready stays high; each stage has its own valid and
//   loads whenever it is empty or its successor moves.
// Reset
//   rst_n low clears all stage valids; no result is shown after reset
//   until an item arrives. No state is kept between items.
// Back-pressure
//   When out_if.ready is low the result holds; the two earlier stages
//   still fill, so up to three items are held before in_if.ready drops.

module yuyv_to_rgb_scaled_top (
  input  logic              clk,
  input  logic              rst_n,
  yrgb_in_if.sink           in_if,
  yrgb_out_if.source        out_if
);

  localparam int PIX_W  = yrgb_pkg::PIX_W;
  localparam int DIFF_W = yrgb_pkg::DIFF_W;
  localparam int PROD_W = yrgb_pkg::PROD_W;
  localparam int TERM_W = yrgb_pkg::TERM_W;

  // Stage valids and payloads
  logic                  a_vld_r, a_vld_nxt;
  logic                  b_vld_r, b_vld_nxt;
  logic                  o_vld_r, o_vld_nxt;
  yrgb_pkg::in_stage_t   a_r;
  yrgb_pkg::term_stage_t b_r, b_nxt;
  yrgb_pkg::out_stage_t  o_r, o_nxt;

  logic a_rdy, b_rdy, o_rdy;

  // Ready chain: a stage loads when empty or when it empties this cycle
  assign o_rdy = !o_vld_r || out_if.ready;
  assign b_rdy = !b_vld_r || o_rdy;
  assign a_rdy = !a_vld_r || b_rdy;
  assign in_if.ready = a_rdy;

  assign a_vld_nxt = a_rdy ? in_if.valid : a_vld_r;
  assign b_vld_nxt = b_rdy ? a_vld_r : b_vld_r;
  assign o_vld_nxt = o_rdy ? b_vld_r : o_vld_r;

  // Chroma offsets: flipping the top bit gives value - 128 as signed
  logic signed [DIFF_W-1:0] du, dv;
  logic signed [PROD_W-1:0] rv_prod, gv_prod, gu_prod, bu_prod, g_sum;

  assign du = $signed({~a_r.u[PIX_W-1], ~a_r.u[PIX_W-1], a_r.u[PIX_W-2:0]});
  assign dv = $signed({~a_r.v[PIX_W-1], ~a_r.v[PIX_W-1], a_r.v[PIX_W-2:0]});

  assign rv_prod = PROD_W'(yrgb_pkg::COEF_RV) * PROD_W'(dv);
  assign gv_prod = PROD_W'(yrgb_pkg::COEF_GV) * PROD_W'(dv);
  assign gu_prod = PROD_W'(yrgb_pkg::COEF_GU) * PROD_W'(du);
  assign bu_prod = PROD_W'(yrgb_pkg::COEF_BU) * PROD_W'(du);
  assign g_sum   = -(gv_prod + gu_prod);

  always_comb begin
    b_nxt.y0     = a_r.y0;
    b_nxt.y1     = a_r.y1;
    b_nxt.r_term = rv_prod[TERM_W-1:0];
    b_nxt.g_term = g_sum[TERM_W-1:0];
    b_nxt.b_term = bu_prod[TERM_W-1:0];
    b_nxt.fe     = a_r.fe;
  end

  // Finish both pixels from the shared chroma terms
  yrgb_pkg::rgb_t pix0, pix1;

  yrgb_pixel u_pix0 (
    .y      (b_r.y0),
    .r_term (b_r.r_term),
    .g_term (b_r.g_term),
    .b_term (b_r.b_term),
    .rgb    (pix0)
  );

  yrgb_pixel u_pix1 (
    .y      (b_r.y1),
    .r_term (b_r.r_term),
    .g_term (b_r.g_term),
    .b_term (b_r.b_term),
    .rgb    (pix1)
  );

  always_comb begin
    o_nxt.pix0 = pix0;
    o_nxt.pix1 = pix1;
    o_nxt.fe   = b_r.fe;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  // Payload registers: advance with the ready chain, hold otherwise
  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_r.y0 <= in_if.luma_first;
      a_r.u  <= in_if.chroma_blue;
      a_r.y1 <= in_if.luma_second;
      a_r.v  <= in_if.chroma_red;
      a_r.fe <= in_if.frame_end_in;
    end
    if (b_rdy) begin
      b_r <= b_nxt;
    end
    if (o_rdy) begin
      o_r <= o_nxt;
    end
  end

  // Drive the result channel from the result register
  assign out_if.valid         = o_vld_r;
  assign out_if.red_first     = o_r.pix0.r;
  assign out_if.green_first   = o_r.pix0.g;
  assign out_if.blue_first    = o_r.pix0.b;
  assign out_if.red_second    = o_r.pix1.r;
  assign out_if.green_second  = o_r.pix1.g;
  assign out_if.blue_second   = o_r.pix1.b;
  assign out_if.frame_end_out = o_r.fe;

  // Scaled channels never exceed 219
  assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r |-> (o_r.pix0.r <= yrgb_pkg::OUT_MAX && o_r.pix0.g <= yrgb_pkg::OUT_MAX &&
                 o_r.pix0.b <= yrgb_pkg::OUT_MAX))
    else $error("first pixel channel above scaled maximum");

  assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r |-> (o_r.pix1.r <= yrgb_pkg::OUT_MAX && o_r.pix1.g <= yrgb_pkg::OUT_MAX &&
                 o_r.pix1.b <= yrgb_pkg::OUT_MAX))
    else $error("second pixel channel above scaled maximum");

  // A filled stage always moves into an empty successor
  assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && !o_vld_r) |=> o_vld_r)
    else $error("product stage failed to advance into empty result register");

  assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !b_vld_r) |=> b_vld_r)
    else $error("input stage failed to advance into empty product stage");

endmodule
